FILE: hw/rtl/shabsh_pkg.sv
`timescale 1ns / 1ps

package shabsh_pkg;

    localparam int WordW = 32;
    localparam int Rounds = 64;
    localparam int DigestWords = 8;

    typedef logic [WordW-1:0] word_t;

    typedef enum logic [1:0] {
        BYTE_IN,
        BYTE_PAD80,
        BYTE_ZERO,
        BYTE_LEN
    } byte_sel_t;

    // Controller to datapath command bundle
    typedef struct packed {
        logic      push;       // shift one byte into the block
        byte_sel_t byte_sel;   // source of that byte
        logic      word_done;  // byte completes a 32-bit word
        logic [2:0] len_idx;   // length byte position, 0 is most significant
        logic      start;      // load working vars from chain
        logic      round;      // run one compression round
        logic [5:0] round_idx;
        logic      add;        // fold working vars into chain
        logic      init;       // restart chain and length
        logic [2:0] word_sel;  // digest word on output
    } cmd_t;

    localparam word_t RoundK [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t InitHash [DigestWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

FILE: hw/rtl/sha256_byte_stream_hasher_top.sv
`timescale 1ns / 1ps

// Channel  | Dir | tdata            | tuser          | tlast
// ---------+-----+------------------+----------------+---------------
// s_       | in  | [7:0] data_byte  | [0] has_byte   | end_of_message
// m_       | out | [31:0] digest    | [2:0] word_idx | last_word
//
// One item at a time. A byte that does not finish a block leaves the input
// ready for the next byte. A byte finishing a 64-byte block runs the rounds
// (one round per cycle through the single round unit), then a chain add. End
// of message inserts padding bytes one per cycle (up to 72 over two blocks)
// and one or two compressions, then 8 beats.
// Async active-low reset restores the initial hash; m_ stalls hold the word.

module sha256_byte_stream_hasher_top
(
    input  logic        clk,
    input  logic        rst_n,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // end_of_message
    // digest word stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);
    import shabsh_pkg::*;

    cmd_t cmd;

    // Controller: byte count, padding sequence, round counter, output index
    shabsh_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .has_byte (s_tuser[0]),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .cmd      (cmd)
    );

    // Datapath: schedule window, working vars, chain, bit length
    shabsh_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (s_tdata),
        .digest_word (m_tdata)
    );

    assign m_tuser = cmd.word_sel;

endmodule

FILE: hw/rtl/shabsh_ctrl.sv
`timescale 1ns / 1ps

module shabsh_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              has_byte,
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              m_tlast,
    output shabsh_pkg::cmd_t  cmd
);
    import shabsh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] fill_reg, fill_next;
    logic [5:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;
    logic       fin_reg, fin_next;     // message end seen, cleared after the last digest word
    logic       first_reg, first_next; // 0x80 still to be placed
    logic       wrap_reg, wrap_next;   // padding spills into a second block

    logic s_fire, m_fire, block_full;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == S_OUT);
    assign m_fire   = m_tvalid && m_tready;
    assign m_tlast  = m_tvalid && (idx_reg == 3'd7);

    always_comb
    begin
        cmd = '0;
        cmd.push = (s_fire && has_byte) || (state_reg == S_PAD);
        if (state_reg == S_IDLE)
        begin
            cmd.byte_sel = BYTE_IN;
        end
        else if (first_reg)
        begin
            cmd.byte_sel = BYTE_PAD80;
        end
        else if (wrap_reg || (fill_reg < 6'd56))
        begin
            cmd.byte_sel = BYTE_ZERO;
        end
        else
        begin
            cmd.byte_sel = BYTE_LEN;
        end
        cmd.word_done = (fill_reg[1:0] == 2'd3);
        cmd.len_idx   = fill_reg[2:0];
        block_full    = cmd.push && (fill_reg == 6'd63);
        cmd.start     = block_full;
        cmd.round     = (state_reg == S_ROUND);
        cmd.round_idx = rnd_reg;
        cmd.add       = (state_reg == S_ADD);
        cmd.init      = m_fire && (idx_reg == 3'd7);
        cmd.word_sel  = idx_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next  = cmd.push ? fill_reg + 6'd1 : fill_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        fin_next   = fin_reg;
        first_next = first_reg;
        wrap_next  = wrap_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    if (block_full)
                    begin
                        state_next = S_ROUND;
                        rnd_next   = '0;
                        fin_next   = s_tlast;
                        first_next = s_tlast;
                    end
                    else if (s_tlast)
                    begin
                        state_next = S_PAD;
                        fin_next   = 1'b1;
                        first_next = 1'b1;
                    end
                end
            end
            S_PAD:
            begin
                first_next = 1'b0;
                if (first_reg && (fill_reg >= 6'd56))
                begin
                    wrap_next = 1'b1;
                end
                if (block_full)
                begin
                    state_next = S_ROUND;
                    rnd_next   = '0;
                end
            end
            S_ROUND:
            begin
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                if (!fin_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (first_reg || wrap_reg)
                begin
                    state_next = S_PAD;
                    wrap_next  = 1'b0;
                end
                else
                begin
                    state_next = S_OUT;
                    idx_next   = '0;
                end
            end
            S_OUT:
            begin
                if (m_fire)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        state_next = S_IDLE;
                        fin_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
            first_reg <= 1'b0;
            wrap_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
            first_reg <= first_next;
            wrap_reg  <= wrap_next;
        end
    end

endmodule

FILE: hw/rtl/shabsh_datapath.sv
`timescale 1ns / 1ps

module shabsh_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  shabsh_pkg::cmd_t  cmd,
    input  logic [7:0]        data_byte,
    output shabsh_pkg::word_t digest_word
);
    import shabsh_pkg::*;

    word_t       chain_reg [DigestWords];
    word_t       v_reg [DigestWords];
    word_t       w_reg [16];          // schedule window, w_reg[0] is current word
    logic [23:0] asm_reg;             // partial word, bytes big-endian
    logic [63:0] len_reg;             // message bit count, wraps

    logic [7:0] byte_val;
    word_t      new_word, sched_next, t1, t2, ch, maj;

    always_comb
    begin
        case (cmd.byte_sel)
            BYTE_IN:    byte_val = data_byte;
            BYTE_PAD80: byte_val = 8'h80;
            BYTE_ZERO:  byte_val = 8'h00;
            BYTE_LEN:   byte_val = len_reg[8*(7-cmd.len_idx) +: 8];
            default:    byte_val = 8'h00;
        endcase
    end

    assign new_word   = {asm_reg, byte_val};
    assign sched_next = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];

    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + big_sigma1(v_reg[4]) + ch + RoundK[cmd.round_idx] + w_reg[0];
    assign t2  = big_sigma0(v_reg[0]) + maj;

    assign digest_word = chain_reg[cmd.word_sel];

    // Chain and length carry reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DigestWords; i++)
            begin
                chain_reg[i] <= InitHash[i];
            end
            len_reg <= '0;
        end
        else
        begin
            if (cmd.init)
            begin
                for (int i = 0; i < DigestWords; i++)
                begin
                    chain_reg[i] <= InitHash[i];
                end
                len_reg <= '0;
            end
            else
            begin
                if (cmd.add)
                begin
                    for (int i = 0; i < DigestWords; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + v_reg[i];
                    end
                end
                if (cmd.push && (cmd.byte_sel == BYTE_IN))
                begin
                    len_reg <= len_reg + 64'd8;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            asm_reg <= new_word[23:0];
            if (cmd.word_done)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[15] <= new_word;
            end
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= sched_next;
        end

        if (cmd.start)
        begin
            for (int i = 0; i < DigestWords; i++)
            begin
                v_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule
